FILE: hdl/wba_pkg.sv
// wba_pkg: shared types and constants of the workspace bump allocator
// table sizes, derived index widths, operation and status codes, sequencer states
// no dependencies
package wba_pkg;

	// table sizes
	localparam int MAX_REGIONS = 8;
	localparam int MAX_RECORDS = 32;

	// widths derived from the table sizes
	localparam int REG_IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int REG_CNT_W = $clog2(MAX_REGIONS + 1);
	localparam int REC_IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int REC_CNT_W = $clog2(MAX_RECORDS + 1);

	// operation codes
	localparam logic [1:0] FN_ADD   = 2'd0;
	localparam logic [1:0] FN_RESET = 2'd1;
	localparam logic [1:0] FN_ALLOC = 2'd2;
	localparam logic [1:0] FN_FREE  = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOBASE   = 3'd1;
	localparam logic [2:0] ST_NOFIT    = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	// sequencer states
	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_REGION_SCAN,
		SEQ_RECORD_SCAN,
		SEQ_DONE
	} seq_state_t;

endpackage

FILE: hdl/workspace_bump_allocator.sv
// add and reset requests go from idle to the done state; an allocate or free that can go on
// first runs the region scan or the record scan, one region or one record per cycle
// the done state loads the result into the registered outputs, waiting while out_stall holds one
// one request at a time: a new request is taken only in idle, after the done state
// arst_n clears base address, region count, record count, sequencer and output valid
// workspace_bump_allocator: first-fit bump allocator with a stack of handed-out addresses
// depends on wba_pkg
module workspace_bump_allocator
	import wba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] base_address,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] region_offset,
	input  logic [30:0] region_size,
	input  logic [30:0] req_size,
	input  logic [31:0] free_address,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [31:0] alloc_address,
	output logic [2:0]  status
);

	seq_state_t state_q, state_d;

	logic [31:0]          base_q;
	logic [REG_CNT_W-1:0] region_count_q;
	logic [REC_CNT_W-1:0] alloc_count_q;
	logic                 out_valid_q;

	logic [31:0] region_offsets_q [MAX_REGIONS];
	logic [30:0] region_sizes_q   [MAX_REGIONS];
	logic [31:0] alloc_records_q  [MAX_RECORDS];

	logic [1:0]           func_q;
	logic [30:0]          req_q;
	logic [31:0]          faddr_q;
	logic [REG_IDX_W-1:0] reg_idx_q;
	logic [REC_IDX_W-1:0] rec_idx_q;

	logic        res_ok_q;
	logic [31:0] res_addr_q;
	logic [2:0]  res_status_q;
	logic        ok_q;
	logic [31:0] alloc_address_q;
	logic [2:0]  status_q;

	logic in_take;
	logic out_take;
	logic done_load;
	logic region_fit;
	logic region_last;
	logic record_hit;
	logic record_last;
	logic region_full;
	logic record_full;
	logic base_unset;
	logic [31:0] scan_addr;

	// handshakes and scan compares
	assign cfg_ready   = 1'b1;
	assign in_take     = in_valid && !in_stall;
	assign out_take    = out_valid_q && !out_stall;
	assign done_load   = (state_q == SEQ_DONE) && (!out_valid_q || !out_stall);
	assign region_fit  = region_sizes_q[reg_idx_q] >= req_q;
	assign region_last = REG_CNT_W'(reg_idx_q) == (region_count_q - REG_CNT_W'(1));
	assign record_hit  = alloc_records_q[rec_idx_q] == faddr_q;
	assign record_last = rec_idx_q == '0;
	assign region_full = region_count_q == REG_CNT_W'(MAX_REGIONS);
	assign record_full = alloc_count_q == REC_CNT_W'(MAX_RECORDS);
	assign base_unset  = base_q == 32'd0;
	assign scan_addr   = base_q + region_offsets_q[reg_idx_q];

	assign out_valid     = out_valid_q;
	assign ok            = ok_q;
	assign alloc_address = alloc_address_q;
	assign status        = status_q;

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and request stall
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			SEQ_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (func)
						FN_ALLOC: begin
							if (base_unset || record_full || region_count_q == '0) begin
								state_d = SEQ_DONE;
							end else begin
								state_d = SEQ_REGION_SCAN;
							end
						end
						FN_FREE: begin
							if (base_unset || alloc_count_q == '0) begin
								state_d = SEQ_DONE;
							end else begin
								state_d = SEQ_RECORD_SCAN;
							end
						end
						default: state_d = SEQ_DONE;
					endcase
				end
			end
			SEQ_REGION_SCAN: begin
				if (region_fit || region_last) begin
					state_d = SEQ_DONE;
				end
			end
			SEQ_RECORD_SCAN: begin
				if (record_hit || record_last) begin
					state_d = SEQ_DONE;
				end
			end
			SEQ_DONE: begin
				if (done_load) begin
					state_d = SEQ_IDLE;
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	// control registers: base, counts, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q         <= 32'd0;
			region_count_q <= '0;
			alloc_count_q  <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				base_q <= base_address;
			end
			if (in_take && func == FN_ADD && !region_full) begin
				region_count_q <= region_count_q + REG_CNT_W'(1);
			end
			if (in_take && func == FN_RESET) begin
				region_count_q <= '0;
				alloc_count_q  <= '0;
			end
			if (state_q == SEQ_REGION_SCAN && region_fit) begin
				alloc_count_q <= alloc_count_q + REC_CNT_W'(1);
			end
			if (state_q == SEQ_RECORD_SCAN && record_hit) begin
				alloc_count_q <= alloc_count_q - REC_CNT_W'(1);
			end
			if (done_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// tables, request capture, scan indexes and result staging
	always_ff @(posedge clk) begin
		if (in_take) begin
			func_q    <= func;
			req_q     <= req_size;
			faddr_q   <= free_address;
			reg_idx_q <= '0;
			rec_idx_q <= REC_IDX_W'(alloc_count_q - REC_CNT_W'(1));
			res_addr_q <= 32'd0;
			case (func)
				FN_ADD: begin
					if (region_full) begin
						res_ok_q     <= 1'b0;
						res_status_q <= ST_FULL;
					end else begin
						region_offsets_q[region_count_q[REG_IDX_W-1:0]] <= region_offset;
						region_sizes_q[region_count_q[REG_IDX_W-1:0]]   <= region_size;
						res_ok_q     <= 1'b1;
						res_status_q <= ST_OK;
					end
				end
				FN_RESET: begin
					res_ok_q     <= 1'b1;
					res_status_q <= ST_OK;
				end
				FN_ALLOC: begin
					res_ok_q <= 1'b0;
					if (base_unset) begin
						res_status_q <= ST_NOBASE;
					end else if (record_full) begin
						res_status_q <= ST_FULL;
					end else begin
						res_status_q <= ST_NOFIT;
					end
				end
				default: begin
					res_ok_q <= 1'b0;
					if (base_unset) begin
						res_status_q <= ST_NOBASE;
					end else begin
						res_status_q <= ST_NOTFOUND;
					end
				end
			endcase
		end

		// first-fit region scan, one region per cycle
		if (state_q == SEQ_REGION_SCAN) begin
			if (region_fit) begin
				region_offsets_q[reg_idx_q] <= region_offsets_q[reg_idx_q] + {1'b0, req_q};
				region_sizes_q[reg_idx_q]   <= region_sizes_q[reg_idx_q] - req_q;
				alloc_records_q[alloc_count_q[REC_IDX_W-1:0]] <= scan_addr;
				res_ok_q     <= 1'b1;
				res_addr_q   <= scan_addr;
				res_status_q <= ST_OK;
			end else begin
				reg_idx_q <= reg_idx_q + REG_IDX_W'(1);
			end
		end

		// record search, newest to oldest
		if (state_q == SEQ_RECORD_SCAN) begin
			if (record_hit) begin
				res_ok_q     <= 1'b1;
				res_status_q <= ST_OK;
			end else begin
				rec_idx_q <= rec_idx_q - REC_IDX_W'(1);
			end
		end

		// output register
		if (done_load) begin
			ok_q            <= res_ok_q;
			alloc_address_q <= res_addr_q;
			status_q        <= res_status_q;
		end
	end

`ifndef SYNTH
	// counts never pass their table sizes
	assert property (@(posedge clk) disable iff (!arst_n)
		(region_count_q <= REG_CNT_W'(MAX_REGIONS)) && (alloc_count_q <= REC_CNT_W'(MAX_RECORDS)))
	else $error("table count beyond capacity");

	// region scan index stays inside the filled part of the table
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SEQ_REGION_SCAN |-> REG_CNT_W'(reg_idx_q) < region_count_q)
	else $error("region scan index out of range");

	// record scan only runs while records are held
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SEQ_RECORD_SCAN |-> REC_CNT_W'(rec_idx_q) < alloc_count_q)
	else $error("record scan index out of range");

	// a new result only follows the done state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == SEQ_DONE)
	else $error("result raised outside done state");

	// result fields agree with each other
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (ok_q == (status_q == ST_OK)) && (ok_q || alloc_address_q == 32'd0))
	else $error("inconsistent result fields");

	// a region scan only runs for an allocate request
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SEQ_REGION_SCAN |-> func_q == FN_ALLOC)
	else $error("region scan without allocate request");
`endif

endmodule

FILE: bench/wba_checker.sv
`timescale 1ns / 100ps
// wba_checker: watches the config, request and result channels of the bump allocator,
// predicts every result from its own copy of the tables and compares field by field
// depends on wba_pkg
module wba_checker
	import wba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] base_address,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] region_offset,
	input  logic [30:0] region_size,
	input  logic [30:0] req_size,
	input  logic [31:0] free_address,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        ok,
	input  logic [31:0] alloc_address,
	input  logic [2:0]  status,
	output int          n_pending,
	output int          n_fail
);

	typedef struct packed {
		logic        ok;
		logic [31:0] addr;
		logic [2:0]  st;
	} outcome_t;

	// shadow copy of the allocator state
	logic [31:0] shadow_base;
	logic [31:0] shadow_offsets [MAX_REGIONS];
	logic [30:0] shadow_sizes [MAX_REGIONS];
	int          shadow_regions;
	logic [31:0] shadow_handed [MAX_RECORDS];
	int          shadow_handed_cnt;

	outcome_t expected_outcomes [$];
	int       fails = 0;

	assign n_fail = fails;

	// apply one request to the shadow tables and give the outcome it should produce
	function automatic outcome_t apply_request(input logic [1:0] f, input logic [31:0] off,
			input logic [30:0] sz, input logic [30:0] rq, input logic [31:0] fa);
		outcome_t res;
		bit       done;
		res = '{1'b0, 32'd0, ST_OK};
		done = 0;
		if (f == FN_ADD) begin
			if (shadow_regions >= MAX_REGIONS) begin
				res.st = ST_FULL;
			end else begin
				shadow_offsets[shadow_regions] = off;
				shadow_sizes[shadow_regions] = sz;
				shadow_regions++;
				res.ok = 1'b1;
			end
		end else if (f == FN_RESET) begin
			shadow_regions = 0;
			shadow_handed_cnt = 0;
			res.ok = 1'b1;
		end else if (shadow_base == 32'd0) begin
			res.st = ST_NOBASE;
		end else if (f == FN_ALLOC) begin
			if (shadow_handed_cnt >= MAX_RECORDS) begin
				res.st = ST_FULL;
			end else begin
				// first fit in table order
				for (int i = 0; i < shadow_regions && !done; i++) begin
					if (shadow_sizes[i] >= rq) begin
						res.ok = 1'b1;
						res.addr = shadow_base + shadow_offsets[i];
						shadow_offsets[i] = shadow_offsets[i] + {1'b0, rq};
						shadow_sizes[i] = shadow_sizes[i] - rq;
						shadow_handed[shadow_handed_cnt] = res.addr;
						shadow_handed_cnt++;
						done = 1;
					end
				end
				if (!done)
					res.st = ST_NOFIT;
			end
		end else begin
			// free: newest record first, a hit only pops the count
			for (int i = shadow_handed_cnt; i > 0 && !done; i--) begin
				if (shadow_handed[i - 1] == fa) begin
					shadow_handed_cnt--;
					res.ok = 1'b1;
					done = 1;
				end
			end
			if (!done)
				res.st = ST_NOTFOUND;
		end
		return res;
	endfunction

	// compare accepted results, then queue the prediction for an accepted request
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			shadow_base <= 32'd0;
			shadow_regions = 0;
			shadow_handed_cnt = 0;
			expected_outcomes.delete();
			n_pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_outcomes.size() == 0) begin
					$error("unexpected result: ok %0d alloc_address 0x%08h status %0d",
						ok, alloc_address, status);
					fails++;
				end else begin
					want = expected_outcomes.pop_front();
					if (ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, ok);
						fails++;
					end
					if (alloc_address !== want.addr) begin
						$error("alloc_address: expected 0x%08h, got 0x%08h",
							want.addr, alloc_address);
						fails++;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						fails++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_outcomes.push_back(apply_request(func, region_offset, region_size,
					req_size, free_address));
			if (cfg_valid && cfg_ready)
				shadow_base <= base_address;
			n_pending <= expected_outcomes.size();
		end
	end

endmodule

FILE: bench/tb_workspace_bump_allocator.sv
`timescale 1ns / 100ps
// tb_workspace_bump_allocator: stimulus and verdict for the workspace bump allocator
// depends on wba_pkg, workspace_bump_allocator and wba_checker
module tb_workspace_bump_allocator;
	import wba_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_QUOTA = 325;
	localparam int DRAIN_CYCLES = MAX_RECORDS + 4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] base_address = 32'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = FN_ADD;
	logic [31:0] region_offset = 32'd0;
	logic [30:0] region_size = 31'd0;
	logic [30:0] req_size = 31'd0;
	logic [31:0] free_address = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        ok;
	logic [31:0] alloc_address;
	logic [2:0]  status;

	int n_pending;
	int n_fail;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_trigger = 0;
	int n_sent = 0;
	logic [31:0] handed_pool [$];

	workspace_bump_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.base_address  (base_address),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.region_offset (region_offset),
		.region_size   (region_size),
		.req_size      (req_size),
		.free_address  (free_address),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.ok            (ok),
		.alloc_address (alloc_address),
		.status        (status)
	);

	wba_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.base_address  (base_address),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.region_offset (region_offset),
		.region_size   (region_size),
		.req_size      (req_size),
		.free_address  (free_address),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.ok            (ok),
		.alloc_address (alloc_address),
		.status        (status),
		.n_pending     (n_pending),
		.n_fail        (n_fail)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// result side: random stall, or a long hold-off when asked
	initial begin
		int hold_left;
		int seen_trigger;
		hold_left = 0;
		seen_trigger = 0;
		forever begin
			@(posedge clk);
			if (hold_trigger != seen_trigger) begin
				seen_trigger = hold_trigger;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// keep recent addresses handed out so that frees can hit
	always @(posedge clk) begin
		if (out_valid && !out_stall && ok && alloc_address != 32'd0) begin
			handed_pool.push_back(alloc_address);
			if (handed_pool.size() > 48)
				void'(handed_pool.pop_front());
		end
	end

	// watchdog on cycles with no handshake at all
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// offer one request, with a random gap first
	task automatic send_req(input logic [1:0] f, input logic [31:0] off, input logic [30:0] sz,
			input logic [30:0] rq, input logic [31:0] fa);
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
		in_valid <= 1'b1;
		func <= f;
		region_offset <= off;
		region_size <= sz;
		req_size <= rq;
		free_address <= fa;
		do @(posedge clk); while (in_stall);
		n_sent++;
	endtask

	// write the base register once the block has answered everything
	task automatic write_base(input logic [31:0] value);
		in_valid <= 1'b0;
		do @(posedge clk); while (n_pending != 0);
		cfg_valid <= 1'b1;
		base_address <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [30:0] pick_region_size();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			return 31'($urandom);
		else if (sel < 7)
			return 31'($urandom_range(0, 4096));
		else if (sel < 9)
			return 31'($urandom_range(0, 3));
		return 31'h7FFF_FFFF;
	endfunction

	function automatic logic [30:0] pick_req_size();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 7)
			return 31'($urandom_range(0, 64));
		else if (sel < 9)
			return 31'($urandom_range(0, 8192));
		return 31'($urandom);
	endfunction

	function automatic logic [31:0] pick_free_address();
		if (handed_pool.size() > 0 && $urandom_range(0, 99) < 80)
			return handed_pool[$urandom_range(0, handed_pool.size() - 1)];
		return $urandom;
	endfunction

	// one episode: usually clear, add some regions, then a run of mixed requests
	task automatic run_episode(input bit fill_mode);
		int n_regions;
		int n_ops;
		int pick;
		int alloc_pct;
		int free_pct;
		if ($urandom_range(0, 99) < 80)
			send_req(FN_RESET, $urandom, 31'($urandom), 31'($urandom), $urandom);
		n_regions = $urandom_range(1, MAX_REGIONS + 1);
		repeat (n_regions)
			send_req(FN_ADD, $urandom, pick_region_size(), 31'($urandom), $urandom);
		n_ops = fill_mode ? $urandom_range(30, 42) : $urandom_range(8, 30);
		alloc_pct = fill_mode ? 90 : 55;
		free_pct = fill_mode ? 97 : 85;
		repeat (n_ops) begin
			pick = $urandom_range(0, 99);
			if (pick < alloc_pct)
				send_req(FN_ALLOC, $urandom, 31'($urandom), pick_req_size(), $urandom);
			else if (pick < free_pct)
				send_req(FN_FREE, $urandom, 31'($urandom), 31'($urandom), pick_free_address());
			else if (pick < 93)
				send_req(FN_ADD, $urandom, pick_region_size(), 31'($urandom), $urandom);
			else if (pick < 96)
				send_req(FN_RESET, $urandom, 31'($urandom), 31'($urandom), $urandom);
			else
				send_req(2'($urandom), $urandom, 31'($urandom), 31'($urandom), $urandom);
		end
	endtask

	// stimulus and verdict
	initial begin
		int episode;
		int base_sel;
		logic [31:0] next_base;
		episode = 0;
		base_sel = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// base unset after reset: allocate and free refused, add and reset still work
		send_req(FN_ALLOC, $urandom, 31'($urandom), 31'd5, $urandom);
		send_req(FN_FREE, $urandom, 31'($urandom), 31'($urandom), 32'd0);
		send_req(FN_ADD, 32'hFFFF_FFF0, 31'h7FFF_FFFF, 31'($urandom), $urandom);
		send_req(FN_RESET, $urandom, 31'($urandom), 31'($urandom), $urandom);

		// all-ones base: address and offset wrap, zero request, nothing left
		write_base(32'hFFFF_FFFF);
		send_req(FN_ADD, 32'hFFFF_FFF0, 31'h7FFF_FFFF, 31'($urandom), $urandom);
		send_req(FN_ALLOC, $urandom, 31'($urandom), 31'd0, $urandom);
		send_req(FN_ALLOC, $urandom, 31'($urandom), 31'h7FFF_FFFF, $urandom);
		send_req(FN_ALLOC, $urandom, 31'($urandom), 31'd1, $urandom);
		send_req(FN_FREE, $urandom, 31'($urandom), 31'($urandom), 32'hFFFF_FFEF);
		send_req(FN_FREE, $urandom, 31'($urandom), 31'($urandom), 32'h1234_5678);

		// fill the region table, then one add too many
		for (int i = 1; i < MAX_REGIONS; i++)
			send_req(FN_ADD, 32'(i) << 12, 31'h100, 31'($urandom), $urandom);
		send_req(FN_ADD, $urandom, 31'($urandom), 31'($urandom), $urandom);
		send_req(FN_ALLOC, $urandom, 31'($urandom), 31'h100, $urandom);
		send_req(FN_FREE, $urandom, 31'($urandom), 31'($urandom), 32'hFFFF_FFFF);

		// empty tables: nothing fits, nothing to free
		send_req(FN_RESET, $urandom, 31'($urandom), 31'($urandom), $urandom);
		send_req(FN_ALLOC, $urandom, 31'($urandom), 31'd0, $urandom);
		send_req(FN_FREE, $urandom, 31'($urandom), 31'($urandom), 32'd0);

		// smallest nonzero base with an empty region
		write_base(32'd1);
		send_req(FN_ADD, 32'd0, 31'd0, 31'($urandom), $urandom);
		send_req(FN_ALLOC, $urandom, 31'($urandom), 31'd0, $urandom);

		// random part in four idling phases
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 49;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 49;
				end
				default: begin
					idle_pct = 30;
					stall_pct = 30;
				end
			endcase
			// long hold-off on results while requests keep coming
			if (phase == 0)
				hold_trigger++;
			while (n_sent < 25 + (phase + 1) * PHASE_QUOTA) begin
				if (episode % 3 == 0) begin
					case (base_sel % 6)
						0: next_base = 32'hFFFF_FFFF;
						1: next_base = $urandom;
						2: next_base = 32'd0;
						3: next_base = 32'h8000_0000;
						4: next_base = 32'd1;
						default: next_base = $urandom;
					endcase
					write_base(next_base);
					base_sel++;
				end
				run_episode($urandom_range(0, 99) < 30);
				episode++;
			end
		end

		// drain and verdict
		in_valid <= 1'b0;
		do @(posedge clk); while (n_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_fail == 0 && n_pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
